/* src/tsf_pkg.sv */
`timescale 1ns / 1ps
// Package for the temperature sensor filter: widths, reset values, register
// indexes and the structs passed between the front, queue, divider and back.
// No dependencies.
package tsf_pkg;

    localparam int AVERAGE_SHIFT_DEF = 6;
    localparam int SAMPLE_BITS_DEF   = 10;

    localparam int CFG_W    = 16;
    localparam int OFFSET_W = 8;
    localparam int TEMP_W   = 16;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = ADDR_W - 2;

    // Averages and divisors are carried at the widest sample setting.
    localparam int DIV_D   = 17;
    localparam int DIV_N   = DIV_D + 7;
    localparam int STEP_W  = $clog2(DIV_N + 1);
    localparam int NUM_PAD = DIV_N - CFG_W;

    localparam int SCALE_HUNDRED = 100;

    localparam logic [CFG_W-1:0]    SUPPLY_NUM_RST = 16'd12276;
    localparam logic [CFG_W-1:0]    REF_NUM_RST    = 16'd7173;
    localparam logic [CFG_W-1:0]    COLD_NUM_RST   = 16'd1684;
    localparam logic [CFG_W-1:0]    HOT_NUM_RST    = 16'd1809;
    localparam logic [OFFSET_W-1:0] OFFSET_RST     = 8'd25;

    typedef enum logic [IDX_W-1:0] {
        REG_SUPPLY_NUM = 3'd0,
        REG_REF_NUM    = 3'd1,
        REG_COLD_NUM   = 3'd2,
        REG_HOT_NUM    = 3'd3,
        REG_OFFSET     = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]    supply_num;
        logic [CFG_W-1:0]    ref_num;
        logic [CFG_W-1:0]    cold_num;
        logic [CFG_W-1:0]    hot_num;
        logic [OFFSET_W-1:0] temperature_offset;
    } cfg_t;

    typedef struct packed {
        logic             next_channel;
        logic [DIV_D-1:0] avg_t;
        logic [DIV_D-1:0] avg_b;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_N-1:0]  dividend;
        logic [DIV_D-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } div_rsp_t;

    typedef struct packed {
        logic              next_channel;
        logic [TEMP_W-1:0] temperature;
        logic [CFG_W-1:0]  supply_level;
        logic              valid_res;
    } result_t;

endpackage

/* src/tsf_sample_if.sv */
`timescale 1ns / 1ps
// Sample channel: valid/ready handshake carrying one ADC result.
// Depends on tsf_pkg.
interface tsf_sample_if #(
    parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) ();
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* src/tsf_result_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one filter result.
// Depends on tsf_pkg.
interface tsf_result_if ();
    logic                                valid;
    logic                                ready;
    logic                                next_channel;
    logic signed [tsf_pkg::TEMP_W-1:0]   temperature;
    logic [tsf_pkg::CFG_W-1:0]           supply_level;
    logic                                valid_res;

    modport source (output valid, output next_channel, output temperature,
                    output supply_level, output valid_res, input ready);
    modport sink   (input valid, input next_channel, input temperature,
                    input supply_level, input valid_res, output ready);
endinterface

/* src/tsf_regs.sv */
`timescale 1ns / 1ps
// APB configuration registers of the temperature sensor filter.
// Depends on tsf_pkg.
module tsf_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsf_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsf_pkg::DATA_W-1:0]  pwdata,
    output logic [tsf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output tsf_pkg::cfg_t               cfg
);

    tsf_pkg::cfg_t                  cfg_reg;
    logic [tsf_pkg::IDX_W-1:0]      idx;
    logic                           wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[tsf_pkg::ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.supply_num         <= tsf_pkg::SUPPLY_NUM_RST;
            cfg_reg.ref_num            <= tsf_pkg::REF_NUM_RST;
            cfg_reg.cold_num           <= tsf_pkg::COLD_NUM_RST;
            cfg_reg.hot_num            <= tsf_pkg::HOT_NUM_RST;
            cfg_reg.temperature_offset <= tsf_pkg::OFFSET_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tsf_pkg::REG_SUPPLY_NUM: cfg_reg.supply_num <= pwdata[tsf_pkg::CFG_W-1:0];
                tsf_pkg::REG_REF_NUM:    cfg_reg.ref_num    <= pwdata[tsf_pkg::CFG_W-1:0];
                tsf_pkg::REG_COLD_NUM:   cfg_reg.cold_num   <= pwdata[tsf_pkg::CFG_W-1:0];
                tsf_pkg::REG_HOT_NUM:    cfg_reg.hot_num    <= pwdata[tsf_pkg::CFG_W-1:0];
                tsf_pkg::REG_OFFSET:
                    cfg_reg.temperature_offset <= pwdata[tsf_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tsf_pkg::REG_SUPPLY_NUM: prdata = tsf_pkg::DATA_W'(cfg_reg.supply_num);
            tsf_pkg::REG_REF_NUM:    prdata = tsf_pkg::DATA_W'(cfg_reg.ref_num);
            tsf_pkg::REG_COLD_NUM:   prdata = tsf_pkg::DATA_W'(cfg_reg.cold_num);
            tsf_pkg::REG_HOT_NUM:    prdata = tsf_pkg::DATA_W'(cfg_reg.hot_num);
            tsf_pkg::REG_OFFSET:     prdata = tsf_pkg::DATA_W'(cfg_reg.temperature_offset);
            default:                 prdata = '0;
        endcase
    end

endmodule

/* src/tsf_front.sv */
`timescale 1ns / 1ps
// Front end: accepts samples, steers them to the temperature or bandgap
// running-sum filter and queues the new averages. Depends on tsf_pkg.
module tsf_front #(
    parameter int AVERAGE_SHIFT = tsf_pkg::AVERAGE_SHIFT_DEF,
    parameter int SAMPLE_BITS   = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tsf_sample_if.sink           samples,
    input  logic                 q_full,
    output logic                 q_push,
    output tsf_pkg::item_t       q_item
);

    localparam int SUM_W = SAMPLE_BITS + AVERAGE_SHIFT + 1;

    logic             phase_reg;
    logic [SUM_W-1:0] temp_sum_reg;
    logic [SUM_W-1:0] bg_sum_reg;
    logic [SUM_W-1:0] temp_sum_next;
    logic [SUM_W-1:0] bg_sum_next;
    logic [SUM_W-1:0] sum_sel;
    logic [SUM_W:0]   sum_upd;

    assign samples.ready = !q_full;
    assign q_push        = samples.valid && samples.ready;

    always_comb
    begin
        sum_sel = phase_reg ? bg_sum_reg : temp_sum_reg;
        sum_upd = (SUM_W+1)'(sum_sel) + (SUM_W+1)'(samples.sample)
                  - (SUM_W+1)'(sum_sel >> AVERAGE_SHIFT);
        temp_sum_next = phase_reg ? temp_sum_reg : sum_upd[SUM_W-1:0];
        bg_sum_next   = phase_reg ? sum_upd[SUM_W-1:0] : bg_sum_reg;
        q_item.next_channel = !phase_reg;
        q_item.avg_t = tsf_pkg::DIV_D'(temp_sum_next >> AVERAGE_SHIFT);
        q_item.avg_b = tsf_pkg::DIV_D'(bg_sum_next >> AVERAGE_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= 1'b0;
            temp_sum_reg <= '0;
            bg_sum_reg   <= '0;
        end
        else if (q_push)
        begin
            phase_reg    <= !phase_reg;
            temp_sum_reg <= temp_sum_next;
            bg_sum_reg   <= bg_sum_next;
        end
    end

endmodule

/* src/tsf_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of filtered averages between front and back end.
// Depends on tsf_pkg.
module tsf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tsf_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output tsf_pkg::item_t  head,
    output logic            empty
);

    tsf_pkg::item_t entries_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* src/tsf_div.sv */
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle, left-aligned dividend.
// Depends on tsf_pkg.
module tsf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tsf_pkg::div_req_t  req,
    output tsf_pkg::div_rsp_t  rsp
);

    logic                         busy_reg;
    logic                         done_reg;
    logic [tsf_pkg::STEP_W-1:0]   cnt_reg;
    logic [tsf_pkg::DIV_N-1:0]    quo_reg;
    logic [tsf_pkg::DIV_D-1:0]    rem_reg;
    logic [tsf_pkg::DIV_D-1:0]    divisor_reg;
    logic [tsf_pkg::DIV_D:0]      shifted;
    logic [tsf_pkg::DIV_D:0]      trial;
    logic                         fits;

    assign shifted = {rem_reg, quo_reg[tsf_pkg::DIV_N-1]};
    assign trial   = shifted - {1'b0, divisor_reg};
    assign fits    = (shifted >= {1'b0, divisor_reg});

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !req.start && busy_reg && (cnt_reg == tsf_pkg::STEP_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == tsf_pkg::STEP_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg     <= req.dividend;
            rem_reg     <= '0;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[tsf_pkg::DIV_N-2:0], fits};
            rem_reg <= fits ? trial[tsf_pkg::DIV_D-1:0] : shifted[tsf_pkg::DIV_D-1:0];
        end
    end

endmodule

/* src/tsf_back.sv */
`timescale 1ns / 1ps
// Back end: sequences supply, reference, slope and temperature divisions on
// the shared divider and holds the result register. Depends on tsf_pkg.
module tsf_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tsf_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  tsf_pkg::item_t     q_head,
    output logic               q_pop,
    output tsf_pkg::div_req_t  div_req,
    input  tsf_pkg::div_rsp_t  div_rsp,
    tsf_result_if.source       results
);

    localparam int T_W = tsf_pkg::DIV_N + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUPPLY,
        ST_CHECK,
        ST_REF,
        ST_SLOPE,
        ST_TEMP,
        ST_OUT
    } state_t;

    state_t                         state_reg;
    tsf_pkg::item_t                 item_reg;
    logic [tsf_pkg::CFG_W-1:0]      supply_reg;
    logic [tsf_pkg::CFG_W-1:0]      reference_reg;
    logic [tsf_pkg::TEMP_W-1:0]     temperature_reg;
    logic                           cold_reg;
    logic                           valid_res_reg;
    tsf_pkg::div_req_t              div_req_reg;
    tsf_pkg::result_t               out_reg;
    logic                           out_valid_reg;

    logic [tsf_pkg::CFG_W-1:0]      quo16;
    logic                           cold_now;
    logic [tsf_pkg::DIV_D-1:0]      diff;
    logic [tsf_pkg::DIV_N-1:0]      scaled;
    logic signed [T_W-1:0]          off_ext;
    logic signed [T_W-1:0]          t_val;
    logic [tsf_pkg::TEMP_W-1:0]     t_sat;

    function automatic tsf_pkg::div_req_t div_cmd(
        input logic [tsf_pkg::DIV_N-1:0]  dividend,
        input logic [tsf_pkg::DIV_D-1:0]  divisor,
        input logic [tsf_pkg::STEP_W-1:0] steps
    );
        tsf_pkg::div_req_t r;
        r.start    = 1'b1;
        r.dividend = dividend;
        r.divisor  = divisor;
        r.steps    = steps;
        return r;
    endfunction

    assign q_pop   = (state_reg == ST_IDLE) && !q_empty;
    assign div_req = div_req_reg;

    assign results.valid        = out_valid_reg;
    assign results.next_channel = out_reg.next_channel;
    assign results.temperature  = out_reg.temperature;
    assign results.supply_level = out_reg.supply_level;
    assign results.valid_res    = out_reg.valid_res;

    always_comb
    begin
        quo16    = div_rsp.quotient[tsf_pkg::CFG_W-1:0];
        cold_now = (item_reg.avg_t >= tsf_pkg::DIV_D'(quo16));
        diff     = cold_reg ? item_reg.avg_t - tsf_pkg::DIV_D'(reference_reg)
                            : tsf_pkg::DIV_D'(reference_reg) - item_reg.avg_t;
        scaled   = tsf_pkg::DIV_N'(diff) * tsf_pkg::DIV_N'(tsf_pkg::SCALE_HUNDRED);
        off_ext  = T_W'($signed(cfg.temperature_offset));
        t_val    = cold_reg ? off_ext - $signed(T_W'(div_rsp.quotient))
                            : off_ext + $signed(T_W'(div_rsp.quotient));
        // saturate when the bits above the 16-bit sign do not all agree
        if (t_val[T_W-1:tsf_pkg::TEMP_W-1] == '0
            || t_val[T_W-1:tsf_pkg::TEMP_W-1] == '1)
            t_sat = t_val[tsf_pkg::TEMP_W-1:0];
        else if (t_val[T_W-1])
            t_sat = {1'b1, {(tsf_pkg::TEMP_W-1){1'b0}}};
        else
            t_sat = {1'b0, {(tsf_pkg::TEMP_W-1){1'b1}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            supply_reg      <= '0;
            reference_reg   <= '0;
            temperature_reg <= '0;
            cold_reg        <= 1'b0;
            valid_res_reg   <= 1'b0;
            div_req_reg     <= '0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && (!out_valid_reg || results.ready))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && results.ready)
                out_valid_reg <= 1'b0;

            // a command is only issued from a state whose successor waits on done
            if (div_req_reg.start)
                div_req_reg.start <= 1'b0;
            else
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                        if (!q_empty)
                        begin
                            item_reg      <= q_head;
                            valid_res_reg <= 1'b0;
                            if (q_head.avg_b != '0)
                            begin
                                div_req_reg <= div_cmd(
                                    tsf_pkg::DIV_N'(cfg.supply_num) << tsf_pkg::NUM_PAD,
                                    q_head.avg_b, tsf_pkg::STEP_W'(tsf_pkg::CFG_W));
                                state_reg <= ST_SUPPLY;
                            end
                            else
                                state_reg <= ST_CHECK;
                        end
                    end
                    ST_SUPPLY:
                    begin
                        if (div_rsp.done)
                        begin
                            supply_reg <= quo16;
                            state_reg  <= ST_CHECK;
                        end
                    end
                    ST_CHECK:
                    begin
                        if (supply_reg == '0)
                            state_reg <= ST_OUT;
                        else
                        begin
                            div_req_reg <= div_cmd(
                                tsf_pkg::DIV_N'(cfg.ref_num) << tsf_pkg::NUM_PAD,
                                tsf_pkg::DIV_D'(supply_reg),
                                tsf_pkg::STEP_W'(tsf_pkg::CFG_W));
                            state_reg <= ST_REF;
                        end
                    end
                    ST_REF:
                    begin
                        if (div_rsp.done)
                        begin
                            reference_reg <= quo16;
                            cold_reg      <= cold_now;
                            div_req_reg   <= div_cmd(
                                tsf_pkg::DIV_N'(cold_now ? cfg.cold_num : cfg.hot_num)
                                    << tsf_pkg::NUM_PAD,
                                tsf_pkg::DIV_D'(supply_reg),
                                tsf_pkg::STEP_W'(tsf_pkg::CFG_W));
                            state_reg <= ST_SLOPE;
                        end
                    end
                    ST_SLOPE:
                    begin
                        if (div_rsp.done)
                        begin
                            if (quo16 == '0)
                                state_reg <= ST_OUT;
                            else
                            begin
                                div_req_reg <= div_cmd(scaled, tsf_pkg::DIV_D'(quo16),
                                    tsf_pkg::STEP_W'(tsf_pkg::DIV_N));
                                state_reg <= ST_TEMP;
                            end
                        end
                    end
                    ST_TEMP:
                    begin
                        if (div_rsp.done)
                        begin
                            temperature_reg <= t_sat;
                            valid_res_reg   <= 1'b1;
                            state_reg       <= ST_OUT;
                        end
                    end
                    ST_OUT:
                    begin
                        if (!out_valid_reg || results.ready)
                        begin
                            out_reg.next_channel <= item_reg.next_channel;
                            out_reg.temperature  <= temperature_reg;
                            out_reg.supply_level <= supply_reg;
                            out_reg.valid_res    <= valid_res_reg;
                            state_reg            <= ST_IDLE;
                        end
                    end
                    default: state_reg <= ST_IDLE;
                endcase
            end
        end
    end

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && (!out_valid_reg || results.ready))
        |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("result not loaded on leaving output state");

    a_valid_supply: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.valid_res) |-> (out_reg.supply_level != '0))
        else $error("valid temperature with zero supply level");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_SUPPLY || state_reg == ST_REF
                          || state_reg == ST_SLOPE || state_reg == ST_TEMP))
        else $error("divider finished outside a division state");

endmodule

/* src/on_chip_temperature_sensor_filter_unit.sv */
`timescale 1ns / 1ps
// Top level of the bandgap-compensated temperature sensor filter.
// Depends on tsf_pkg, tsf_sample_if, tsf_result_if and all tsf_* modules.
//
//   channel   dir   handshake              payload
//   samples   in    valid/ready            sample
//   results   out   valid/ready            next_channel, temperature,
//                                          supply_level, valid_res
//   apb       in    psel/penable/pready    paddr, pwdata, prdata
//
// A sample is taken into a two-entry queue; the back end then pops it and runs
// the supply, reference, slope and temperature divisions on the shared
// one-bit-per-cycle divider, with check and output steps, and skips divisions
// when the bandgap average, supply or slope is 0. Reset is asynchronous and
// active low; queue entries and divider data registers have no reset, all others do.
// samples.ready drops only while the queue is full; a stalled result waits in
// the output register while the back end works on the next transaction.
module on_chip_temperature_sensor_filter_unit #(
    parameter int AVERAGE_SHIFT = tsf_pkg::AVERAGE_SHIFT_DEF,
    parameter int SAMPLE_BITS   = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tsf_sample_if.sink                  samples,
    tsf_result_if.source                results,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsf_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsf_pkg::DATA_W-1:0]  pwdata,
    output logic [tsf_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);

    tsf_pkg::cfg_t      cfg;
    tsf_pkg::item_t     push_item;
    tsf_pkg::item_t     head;
    logic               push;
    logic               full;
    logic               pop;
    logic               empty;
    tsf_pkg::div_req_t  div_req;
    tsf_pkg::div_rsp_t  div_rsp;

    tsf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsf_front #(
        .AVERAGE_SHIFT (AVERAGE_SHIFT),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .q_full  (full),
        .q_push  (push),
        .q_item  (push_item)
    );

    tsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    tsf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    tsf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (empty),
        .q_head  (head),
        .q_pop   (pop),
        .div_req (div_req),
        .div_rsp (div_rsp),
        .results (results)
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for on_chip_temperature_sensor_filter_unit: a directed table, then random
// sample traffic over many register settings, checked against an in-bench filter model.
// Depends on tsf_pkg, tsf_sample_if, tsf_result_if and the filter RTL.
module tb;

    localparam int CFG_W    = tsf_pkg::CFG_W;
    localparam int IDX_W    = tsf_pkg::IDX_W;
    localparam int DATA_W   = tsf_pkg::DATA_W;
    localparam int ADDR_W   = tsf_pkg::ADDR_W;
    localparam int TEMP_W   = tsf_pkg::TEMP_W;
    localparam int OFFSET_W = tsf_pkg::OFFSET_W;

    localparam int SAMPLE_W   = tsf_pkg::SAMPLE_BITS_DEF;
    localparam int AVG_SHIFT  = tsf_pkg::AVERAGE_SHIFT_DEF;
    localparam int SUM_W      = SAMPLE_W + AVG_SHIFT + 1;
    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int CFG_MAX    = (1 << CFG_W) - 1;

    localparam longint TEMP_MAX = 32767;
    localparam longint TEMP_MIN = -32768;

    localparam logic CH_TEMPERATURE = 1'b0;
    localparam logic CH_BANDGAP     = 1'b1;

    localparam logic [IDX_W-1:0] REG_UNUSED_LO = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_UNUSED_HI = IDX_W'(7);

    localparam int RESET_CYCLES     = 10;
    localparam int SEGMENTS         = 11;
    localparam int CORNER_ITEMS     = 80;
    localparam int SEGMENT_ITEMS    = 47;
    localparam int HOLD_SEGMENT     = 2;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES      = 200;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

    typedef enum logic [2:0] {
        SET_CORNER,
        SET_NOMINAL,
        SET_SCALED,
        SET_WILD,
        SET_EDGES
    } settings_kind_t;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_EVERY_THIRD
    } sink_mode_t;

    typedef struct {
        row_kind_t             kind;
        logic [IDX_W-1:0]      idx;
        logic [DATA_W-1:0]     data;
        logic [SAMPLE_W-1:0]   sample;
        bit                    typed;
        tsf_pkg::result_t      want;
    } step_row_t;

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tsf_sample_if adc_bus ();
    tsf_result_if reading_bus ();

    on_chip_temperature_sensor_filter_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (adc_bus),
        .results (reading_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter model state and register shadow
    tsf_pkg::cfg_t       cfg_q;
    logic                phase_q;
    logic [SUM_W-1:0]    temp_sum_q;
    logic [SUM_W-1:0]    bandgap_sum_q;
    logic [CFG_W-1:0]    supply_q;
    logic [CFG_W-1:0]    reference_q;
    logic [TEMP_W-1:0]   temp_q;

    tsf_pkg::result_t pending_readings[$];
    step_row_t        directed_steps[$];

    int  cycle_count     = 0;
    int  mismatches      = 0;
    int  results_checked = 0;
    int  items_sent      = 0;
    int  reg_writes      = 0;
    int  settings_used   = 0;
    int  saturated_count = 0;
    int  held_count      = 0;
    int  burst_left      = 0;
    bit  steady_sender   = 1'b0;
    bit  long_hold_req   = 1'b0;

    task automatic advance_filter(input logic [SAMPLE_W-1:0] x,
                                  output tsf_pkg::result_t reading);
        logic [SUM_W-1:0] avg_t;
        logic [SUM_W-1:0] avg_b;
        logic [CFG_W-1:0] slope;
        longint           offset_deg;
        longint           diff;
        longint           t;
        bit               updated;
        updated = 1'b0;
        t = 0;
        if (phase_q == CH_TEMPERATURE)
        begin
            temp_sum_q = temp_sum_q + SUM_W'(x) - (temp_sum_q >> AVG_SHIFT);
            phase_q    = CH_BANDGAP;
        end
        else
        begin
            bandgap_sum_q = bandgap_sum_q + SUM_W'(x) - (bandgap_sum_q >> AVG_SHIFT);
            phase_q       = CH_TEMPERATURE;
        end
        avg_t = temp_sum_q >> AVG_SHIFT;
        avg_b = bandgap_sum_q >> AVG_SHIFT;
        if (avg_b != 0)
            supply_q = CFG_W'(cfg_q.supply_num / avg_b);
        if (supply_q != 0)
        begin
            reference_q = cfg_q.ref_num / supply_q;
            offset_deg  = $signed(cfg_q.temperature_offset);
            if (avg_t >= reference_q)
            begin
                slope = cfg_q.cold_num / supply_q;
                if (slope != 0)
                begin
                    diff    = longint'(avg_t) - longint'(reference_q);
                    t       = offset_deg - (diff * tsf_pkg::SCALE_HUNDRED) / longint'(slope);
                    updated = 1'b1;
                end
            end
            else
            begin
                slope = cfg_q.hot_num / supply_q;
                if (slope != 0)
                begin
                    diff    = longint'(reference_q) - longint'(avg_t);
                    t       = offset_deg + (diff * tsf_pkg::SCALE_HUNDRED) / longint'(slope);
                    updated = 1'b1;
                end
            end
        end
        if (updated)
        begin
            if (t > TEMP_MAX || t < TEMP_MIN)
                saturated_count++;
            if (t > TEMP_MAX)
                t = TEMP_MAX;
            else if (t < TEMP_MIN)
                t = TEMP_MIN;
            temp_q = t[TEMP_W-1:0];
        end
        else
            held_count++;
        reading.next_channel = phase_q;
        reading.temperature  = temp_q;
        reading.supply_level = supply_q;
        reading.valid_res    = updated;
    endtask

    task automatic flag_mismatch(string what, longint got, longint want);
        $display("%0t: mismatch, %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic apb_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            tsf_pkg::REG_SUPPLY_NUM: cfg_q.supply_num         = data[CFG_W-1:0];
            tsf_pkg::REG_REF_NUM:    cfg_q.ref_num            = data[CFG_W-1:0];
            tsf_pkg::REG_COLD_NUM:   cfg_q.cold_num           = data[CFG_W-1:0];
            tsf_pkg::REG_HOT_NUM:    cfg_q.hot_num            = data[CFG_W-1:0];
            tsf_pkg::REG_OFFSET:     cfg_q.temperature_offset = data[OFFSET_W-1:0];
            default:                 ;
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_sample(logic [SAMPLE_W-1:0] x, bit typed, tsf_pkg::result_t want);
        tsf_pkg::result_t predicted;
        int               gap;
        gap = 0;
        if (!steady_sender)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                case ($urandom_range(0, 7))
                    0, 1:    gap = 0;
                    7:       gap = $urandom_range(60, 160);
                    default: gap = $urandom_range(1, 12);
                endcase
            end
            burst_left--;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            adc_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        adc_bus.valid  <= 1'b1;
        adc_bus.sample <= x;
        do
            @(posedge clk);
        while (!adc_bus.ready);
        advance_filter(x, predicted);
        pending_readings.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        adc_bus.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    function automatic step_row_t item_row(logic [SAMPLE_W-1:0] x);
        step_row_t row;
        row.kind   = ROW_ITEM;
        row.idx    = '0;
        row.data   = '0;
        row.sample = x;
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic step_row_t known_row(logic [SAMPLE_W-1:0] x, logic nc,
                                            logic [TEMP_W-1:0] temp, logic [CFG_W-1:0] sup,
                                            logic vr);
        step_row_t row;
        row = item_row(x);
        row.typed             = 1'b1;
        row.want.next_channel = nc;
        row.want.temperature  = temp;
        row.want.supply_level = sup;
        row.want.valid_res    = vr;
        return row;
    endfunction

    function automatic step_row_t write_row(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
        step_row_t row;
        row = item_row('0);
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic logic [CFG_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return '1;
            default: return CFG_W'($urandom_range(0, CFG_MAX));
        endcase
    endfunction

    always @(posedge clk)
    begin : check_readings
        tsf_pkg::result_t want;
        cycle_count++;
        if (rst_n && reading_bus.valid && reading_bus.ready)
        begin
            if (pending_readings.size() == 0)
                flag_mismatch("result with none expected", reading_bus.temperature, 0);
            else
            begin
                want = pending_readings.pop_front();
                if (reading_bus.next_channel !== want.next_channel)
                    flag_mismatch("next_channel", reading_bus.next_channel, want.next_channel);
                if (reading_bus.temperature !== want.temperature)
                    flag_mismatch("temperature", reading_bus.temperature,
                                  $signed(want.temperature));
                if (reading_bus.supply_level !== want.supply_level)
                    flag_mismatch("supply_level", reading_bus.supply_level, want.supply_level);
                if (reading_bus.valid_res !== want.valid_res)
                    flag_mismatch("valid_res", reading_bus.valid_res, want.valid_res);
                results_checked++;
            end
        end
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         tick;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                reading_bus.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                reading_bus.ready <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    SINK_OPEN:   reading_bus.ready <= 1'b1;
                    SINK_COIN:   reading_bus.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: reading_bus.ready <= ($urandom_range(0, 3) == 0);
                    default:     reading_bus.ready <= (tick % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        settings_kind_t      kind;
        logic [CFG_W-1:0]    v_supply;
        logic [CFG_W-1:0]    v_ref;
        logic [CFG_W-1:0]    v_cold;
        logic [CFG_W-1:0]    v_hot;
        logic [OFFSET_W-1:0] v_offset;
        logic [SAMPLE_W-1:0] x;
        int                  seg;
        int                  n;
        int                  roll;
        int                  count;

        rst_n             = 1'b0;
        adc_bus.valid     = 1'b0;
        adc_bus.sample    = '0;
        reading_bus.ready = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;

        cfg_q.supply_num         = tsf_pkg::SUPPLY_NUM_RST;
        cfg_q.ref_num            = tsf_pkg::REF_NUM_RST;
        cfg_q.cold_num           = tsf_pkg::COLD_NUM_RST;
        cfg_q.hot_num            = tsf_pkg::HOT_NUM_RST;
        cfg_q.temperature_offset = tsf_pkg::OFFSET_RST;
        phase_q       = CH_TEMPERATURE;
        temp_sum_q    = '0;
        bandgap_sum_q = '0;
        supply_q      = '0;
        reference_q   = '0;
        temp_q        = '0;

        // from reset: no bandgap average yet, so nothing moves
        directed_steps.push_back(known_row(SAMPLE_W'(SAMPLE_MAX), CH_BANDGAP,
                                           TEMP_W'(0), CFG_W'(0), 1'b0));
        directed_steps.push_back(known_row(SAMPLE_W'(0), CH_TEMPERATURE,
                                           TEMP_W'(0), CFG_W'(0), 1'b0));
        directed_steps.push_back(known_row(SAMPLE_W'(0), CH_BANDGAP,
                                           TEMP_W'(0), CFG_W'(0), 1'b0));
        directed_steps.push_back(known_row(SAMPLE_W'(63), CH_TEMPERATURE,
                                           TEMP_W'(0), CFG_W'(0), 1'b0));
        // unmapped indexes, masked upper bits
        directed_steps.push_back(write_row(REG_UNUSED_LO, '1));
        directed_steps.push_back(write_row(REG_UNUSED_HI, '0));
        directed_steps.push_back(write_row(tsf_pkg::REG_SUPPLY_NUM, 32'hFFFF_0001));
        directed_steps.push_back(write_row(tsf_pkg::REG_REF_NUM, 32'h0000_FFFF));
        directed_steps.push_back(write_row(tsf_pkg::REG_HOT_NUM, 32'h0000_0001));
        directed_steps.push_back(known_row(SAMPLE_W'(SAMPLE_MAX), CH_BANDGAP,
                                           TEMP_W'(0), CFG_W'(0), 1'b0));
        // bandgap average 1, supply 1, hot slope 1: positive saturation
        directed_steps.push_back(known_row(SAMPLE_W'(1), CH_TEMPERATURE,
                                           16'h7FFF, CFG_W'(1), 1'b1));
        directed_steps.push_back(write_row(tsf_pkg::REG_OFFSET, 32'h0000_0080));
        directed_steps.push_back(write_row(tsf_pkg::REG_REF_NUM, 32'h0000_0000));
        directed_steps.push_back(write_row(tsf_pkg::REG_COLD_NUM, 32'h0000_0000));
        // cold slope zero: temperature held
        directed_steps.push_back(known_row(SAMPLE_W'(512), CH_BANDGAP,
                                           16'h7FFF, CFG_W'(1), 1'b0));
        directed_steps.push_back(write_row(tsf_pkg::REG_COLD_NUM, 32'h0000_0001));
        directed_steps.push_back(item_row(SAMPLE_W'(1)));
        // supply zero
        directed_steps.push_back(write_row(tsf_pkg::REG_SUPPLY_NUM, 32'h0000_0000));
        directed_steps.push_back(item_row(SAMPLE_W'(700)));
        directed_steps.push_back(item_row(SAMPLE_W'(1)));
        directed_steps.push_back(write_row(tsf_pkg::REG_SUPPLY_NUM, 32'h0000_0021));
        directed_steps.push_back(write_row(tsf_pkg::REG_REF_NUM,
                                           DATA_W'(tsf_pkg::REF_NUM_RST)));
        directed_steps.push_back(write_row(tsf_pkg::REG_COLD_NUM,
                                           DATA_W'(tsf_pkg::COLD_NUM_RST)));
        directed_steps.push_back(write_row(tsf_pkg::REG_HOT_NUM,
                                           DATA_W'(tsf_pkg::HOT_NUM_RST)));
        directed_steps.push_back(write_row(tsf_pkg::REG_OFFSET, 32'h0000_007F));
        directed_steps.push_back(item_row(SAMPLE_W'(SAMPLE_MAX)));
        directed_steps.push_back(item_row(SAMPLE_W'(1)));
        directed_steps.push_back(item_row(SAMPLE_W'(0)));
        directed_steps.push_back(item_row(SAMPLE_W'(1)));
        directed_steps.push_back(write_row(tsf_pkg::REG_SUPPLY_NUM, 32'h0000_FFFF));
        directed_steps.push_back(write_row(tsf_pkg::REG_COLD_NUM, 32'h0000_FFFF));
        directed_steps.push_back(write_row(tsf_pkg::REG_HOT_NUM, 32'h0000_FFFF));
        directed_steps.push_back(item_row(SAMPLE_W'(SAMPLE_MAX)));
        directed_steps.push_back(item_row(SAMPLE_W'(1)));
        directed_steps.push_back(item_row(SAMPLE_W'(300)));
        directed_steps.push_back(item_row(SAMPLE_W'(1)));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == ROW_WRITE)
            begin
                wait_for_drain();
                apb_write(directed_steps[i].idx, directed_steps[i].data);
            end
            else
                send_sample(directed_steps[i].sample, directed_steps[i].typed,
                            directed_steps[i].want);
        end

        // bandgap sum sits at 64 here, so the corner segment runs with supply 1
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_for_drain();
            kind = (seg == 0) ? SET_CORNER : settings_kind_t'(1 + (seg % 4));
            case (kind)
                SET_CORNER:
                begin
                    v_supply = CFG_W'(1);
                    v_ref    = '0;
                    v_cold   = CFG_W'(1);
                    v_hot    = CFG_W'($urandom_range(0, 1));
                    v_offset = OFFSET_W'($urandom);
                end
                SET_NOMINAL:
                begin
                    v_supply = tsf_pkg::SUPPLY_NUM_RST;
                    v_ref    = tsf_pkg::REF_NUM_RST;
                    v_cold   = tsf_pkg::COLD_NUM_RST;
                    v_hot    = tsf_pkg::HOT_NUM_RST;
                    v_offset = tsf_pkg::OFFSET_RST;
                end
                SET_SCALED:
                begin
                    v_supply = CFG_W'($urandom_range(8000, 20000));
                    v_ref    = CFG_W'($urandom_range(5000, 10000));
                    v_cold   = CFG_W'($urandom_range(800, 3000));
                    v_hot    = CFG_W'($urandom_range(800, 3000));
                    v_offset = OFFSET_W'($urandom);
                end
                SET_WILD:
                begin
                    v_supply = CFG_W'($urandom);
                    v_ref    = CFG_W'($urandom);
                    v_cold   = CFG_W'($urandom);
                    v_hot    = CFG_W'($urandom);
                    v_offset = OFFSET_W'($urandom);
                end
                default:
                begin
                    v_supply = pick_extreme();
                    v_ref    = pick_extreme();
                    v_cold   = pick_extreme();
                    v_hot    = pick_extreme();
                    case ($urandom_range(0, 3))
                        0:       v_offset = 8'h80;
                        1:       v_offset = 8'h7F;
                        2:       v_offset = '0;
                        default: v_offset = OFFSET_W'($urandom);
                    endcase
                end
            endcase
            apb_write(tsf_pkg::REG_SUPPLY_NUM, {16'($urandom), v_supply});
            apb_write(tsf_pkg::REG_REF_NUM,    {16'($urandom), v_ref});
            apb_write(tsf_pkg::REG_COLD_NUM,   {16'($urandom), v_cold});
            apb_write(tsf_pkg::REG_HOT_NUM,    {16'($urandom), v_hot});
            apb_write(tsf_pkg::REG_OFFSET,     {24'($urandom), v_offset});
            settings_used++;

            steady_sender = (seg == 0) || (seg == HOLD_SEGMENT) || ($urandom_range(0, 3) == 0);
            count = (kind == SET_CORNER) ? CORNER_ITEMS : SEGMENT_ITEMS;
            for (n = 0; n < count; n++)
            begin
                if (seg == HOLD_SEGMENT && n == 2)
                    long_hold_req = 1'b1;
                roll = $urandom_range(0, 99);
                if (kind == SET_CORNER)
                    x = (phase_q == CH_TEMPERATURE) ? SAMPLE_W'($urandom_range(990, SAMPLE_MAX))
                                                    : SAMPLE_W'(1);
                else if (roll < 80)
                    x = (phase_q == CH_TEMPERATURE) ? SAMPLE_W'($urandom_range(120, 320))
                                                    : SAMPLE_W'($urandom_range(330, 420));
                else if (roll < 93)
                    x = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
                else
                    x = roll[0] ? SAMPLE_W'(SAMPLE_MAX) : '0;
                send_sample(x, 1'b0, '0);
            end
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("run covered %0d samples and %0d results under %0d random settings, %0d writes",
                 items_sent, results_checked, settings_used, reg_writes);
        $display("predicted %0d saturated and %0d held temperatures", saturated_count, held_count);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* on_chip_temperature_sensor_filter_unit.f */
src/tsf_pkg.sv
src/tsf_sample_if.sv
src/tsf_result_if.sv
src/tsf_regs.sv
src/tsf_front.sv
src/tsf_queue.sv
src/tsf_div.sv
src/tsf_back.sv
src/on_chip_temperature_sensor_filter_unit.sv
tb/tb.sv
